FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the reassembler RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define SRR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, always active
`define SRR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Types and fixed constants of the sequenced report reassembler
// ----------------------------------------------------------------------------
package srr_pkg;

  // header layout
  localparam int unsigned HEADER_BYTES = 6;
  localparam int POS_W   = 10;
  localparam int FIELD_W = 16;
  localparam int ADDR_W  = 16;
  localparam int LIMIT_W = 10;
  // packet number times payload size, and that plus an offset
  localparam int PROD_W  = 26;
  localparam int SUM_W   = 27;

  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

  // header byte positions
  localparam logic [POS_W-1:0] POS_TOTAL_LO = 10'd0;
  localparam logic [POS_W-1:0] POS_TOTAL_HI = 10'd1;
  localparam logic [POS_W-1:0] POS_PKT_LO   = 10'd2;
  localparam logic [POS_W-1:0] POS_PKT_HI   = 10'd3;
  localparam logic [POS_W-1:0] POS_REST_LO  = 10'd4;
  localparam logic [POS_W-1:0] POS_REST_HI  = 10'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_report;
  } in_item_t;

  // input register contents
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_slot_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic              message_done;
    logic              sequence_error;
  } result_t;

endpackage

FILE: src/srr_if.sv
// ----------------------------------------------------------------------------
// srr_if
// Valid/ready channels for report bytes and buffer write results
// ----------------------------------------------------------------------------
interface srr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_report;

  modport source (output valid, output data_byte, output end_of_report, input ready);
  modport sink   (input valid, input data_byte, input end_of_report, output ready);
endinterface

interface srr_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic        message_done;
  logic        sequence_error;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output message_done, output sequence_error,
                  input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input write_data, input message_done, input sequence_error,
                  output ready);
endinterface

FILE: src/srr_in_stage.sv
// ----------------------------------------------------------------------------
// srr_in_stage
// Input register: captures one report byte per request
// ----------------------------------------------------------------------------
module srr_in_stage
  import srr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  srr_in_if.sink     in_stream,
  input  logic       advance,
  output in_slot_t   slot
);

  logic     valid;
  in_item_t item;

  // free when empty or when the held byte moves on this cycle
  assign in_stream.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_stream.ready) begin
      valid <= in_stream.valid;
    end
    if (in_stream.valid && in_stream.ready) begin
      item.data_byte     <= in_stream.data_byte;
      item.end_of_report <= in_stream.end_of_report;
    end
  end

  assign slot.valid = valid;
  assign slot.item  = item;

endmodule

FILE: src/srr_track.sv
// ----------------------------------------------------------------------------
// srr_track
// Header capture, sequence check and buffer address generation
// ----------------------------------------------------------------------------
module srr_track
  import srr_pkg::*;
#(
  parameter int REPORT_BYTES = 1024,
  parameter int MAX_PACKETS  = 34
) (
  input  logic     clk,
  input  logic     rst,
  input  in_slot_t slot,
  input  logic     advance,
  output result_t  result
);

  localparam int PAYLOAD_BYTES = REPORT_BYTES - int'(HEADER_BYTES);
  localparam int BUFFER_BYTES  = REPORT_BYTES * MAX_PACKETS;
  localparam logic [LIMIT_W-1:0] PAYLOAD_LIM = LIMIT_W'(PAYLOAD_BYTES);
  localparam logic [FIELD_W-1:0] PAYLOAD_F   = FIELD_W'(PAYLOAD_BYTES);
  localparam logic [SUM_W-1:0]   BUFFER_S    = SUM_W'(BUFFER_BYTES);

  // control state
  logic [POS_W-1:0]   pos, pos_next;
  logic [FIELD_W-1:0] expected, expected_next;
  logic               accepted, accepted_next;
  // header fields and values derived from them
  logic [FIELD_W-1:0] total, total_next;
  logic [FIELD_W-1:0] pkt, pkt_next;
  logic [7:0]         rest_lo, rest_lo_next;
  logic [PROD_W-1:0]  base, base_next;
  logic               last_pkt, last_pkt_next;
  logic [LIMIT_W-1:0] limit, limit_next;

  logic [7:0]         b;
  logic               eor;
  logic [FIELD_W-1:0] rest_full;
  logic [POS_W-1:0]   off;
  logic [SUM_W-1:0]   addr_sum;
  logic               acc_now;

  assign b         = slot.item.data_byte;
  assign eor       = slot.item.end_of_report;
  assign rest_full = {b, rest_lo};
  assign off       = pos - POS_W'(HEADER_BYTES);
  assign addr_sum  = SUM_W'(base) + SUM_W'(off);

  // per-byte decode
  always_comb begin
    total_next     = total;
    pkt_next       = pkt;
    rest_lo_next   = rest_lo;
    base_next      = base;
    last_pkt_next  = last_pkt;
    limit_next     = limit;
    accepted_next  = accepted;
    expected_next  = expected;
    pos_next       = pos;
    result         = '0;

    case (pos)
      POS_TOTAL_LO: total_next = {8'h00, b};
      POS_TOTAL_HI: total_next = {b, total[7:0]};
      POS_PKT_LO:   pkt_next   = {8'h00, b};
      POS_PKT_HI:   pkt_next   = {b, pkt[7:0]};
      POS_REST_LO: begin
        rest_lo_next  = b;
        base_next     = PROD_W'(pkt) * PROD_W'(PAYLOAD_BYTES);
        last_pkt_next = (total != '0) && (pkt == total - 1'b1);
      end
      POS_REST_HI: begin
        accepted_next = (pkt == expected);
        limit_next    = (last_pkt && (rest_full < PAYLOAD_F)) ?
                        LIMIT_W'(rest_full) : PAYLOAD_LIM;
      end
      default: begin
        if (accepted && (off < limit) && (addr_sum < BUFFER_S)) begin
          result.write_enable  = 1'b1;
          result.write_address = addr_sum[ADDR_W-1:0];
          result.write_data    = b;
        end
      end
    endcase

    // end of report: settle the sequence and restart the byte count
    acc_now = (pos == POS_REST_HI) ? accepted_next : accepted;
    if (eor) begin
      if (pos >= POS_REST_HI) begin
        if (acc_now) begin
          if (last_pkt) begin
            result.message_done = 1'b1;
            expected_next       = '0;
          end else begin
            expected_next = expected + 1'b1;
          end
        end else begin
          result.sequence_error = 1'b1;
          expected_next         = '0;
        end
      end
      pos_next      = '0;
      accepted_next = 1'b0;
    end else if (pos < POS_MAX) begin
      pos_next = pos + 1'b1;
    end
  end

  // state update when the held byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      expected <= '0;
      accepted <= 1'b0;
    end else if (advance) begin
      pos      <= pos_next;
      expected <= expected_next;
      accepted <= accepted_next;
    end
    if (advance) begin
      total    <= total_next;
      pkt      <= pkt_next;
      rest_lo  <= rest_lo_next;
      base     <= base_next;
      last_pkt <= last_pkt_next;
      limit    <= limit_next;
    end
  end

endmodule

FILE: src/srr_out_stage.sv
// ----------------------------------------------------------------------------
// srr_out_stage
// Result register driving the write channel
// ----------------------------------------------------------------------------
module srr_out_stage
  import srr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  result_t  result,
  input  logic     load,
  output logic     can_load,
  srr_out_if.source out_stream
);

  logic    valid;
  result_t held;

  // room when empty or the held result leaves this cycle
  assign can_load = !valid || out_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
    if (load) begin
      held <= result;
    end
  end

  assign out_stream.valid          = valid;
  assign out_stream.write_enable   = held.write_enable;
  assign out_stream.write_address  = held.write_address;
  assign out_stream.write_data     = held.write_data;
  assign out_stream.message_done   = held.message_done;
  assign out_stream.sequence_error = held.sequence_error;

endmodule

FILE: src/sequenced_report_reassembler.sv
// ----------------------------------------------------------------------------
// sequenced_report_reassembler
// Reassembles numbered fixed-size reports into a message buffer write stream
// ----------------------------------------------------------------------------
// Usage:
//   in_stream carries report bytes, header first, with end_of_report on the
//   last byte of each report. out_stream returns exactly one result per
//   byte: an optional buffer write (write_enable, write_address, write_data)
//   plus message_done / sequence_error on the end byte of a report.
//   Pipeline: a byte accepted into the input register moves on into the result
//   register, from which it can be taken (input register, then result
//   register). Throughput: one byte per cycle while out_stream is ready; the
//   decode is a header capture, one compare and one address add between the
//   two registers. The packet base address is multiplied out on header byte
//   4 and registered for the payload bytes.
//   Reset: synchronous; clears byte position, expected packet number and
//   both register stages. No request is in flight after reset.
//   Stall: when out_stream.ready is low the result holds; one more byte is
//   still taken into the input register, then in_stream.ready drops until
//   the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sequenced_report_reassembler
  import srr_pkg::*;
#(
  parameter int REPORT_BYTES = 1024,
  parameter int MAX_PACKETS  = 34
) (
  input  logic      clk,
  input  logic      rst,
  srr_in_if.sink    in_stream,
  srr_out_if.source out_stream
);

  in_slot_t slot;
  result_t  result;
  logic     can_load;
  logic     advance;

  // byte moves from input register to result register
  assign advance = slot.valid && can_load;

  srr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_stream),
    .advance   (advance),
    .slot      (slot)
  );

  srr_track #(
    .REPORT_BYTES (REPORT_BYTES),
    .MAX_PACKETS  (MAX_PACKETS)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .slot    (slot),
    .advance (advance),
    .result  (result)
  );

  srr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .load       (advance),
    .can_load   (can_load),
    .out_stream (out_stream)
  );

  // done and error are exclusive outcomes of a report
  `SRR_ASSERT(a_done_xor_err, clk, rst, out_stream.valid |-> !(out_stream.message_done && out_stream.sequence_error), "done and sequence error together")

  // full pipeline with a stalled result must back-pressure the input
  `SRR_ASSERT(a_backpressure, clk, rst, (slot.valid && out_stream.valid && !out_stream.ready) |-> !in_stream.ready, "input accepted with both stages full")

  // a consumed byte always lands in the result register
  `SRR_ASSERT(a_advance_loads, clk, rst, advance |=> out_stream.valid, "consumed byte produced no result")

endmodule

FILE: verif/sequenced_report_reassembler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequenced_report_reassembler_checker
// Watches both streams of the reassembler, predicts the buffer write and the
// message flags for every accepted report byte, and compares them in order
// with the results that the block returns.
// ----------------------------------------------------------------------------
module sequenced_report_reassembler_checker
  import srr_pkg::*;
#(
  parameter int REPORT_BYTES = 1024,
  parameter int MAX_PACKETS  = 34
) (
  input  logic        clk,
  input  logic        rst,
  srr_in_if           in_stream,
  srr_out_if          out_stream,
  output int unsigned mismatch_count,
  output int unsigned writes_outstanding
);

  localparam int unsigned PAYLOAD_SIZE = REPORT_BYTES - HEADER_BYTES;
  localparam int unsigned BUFFER_SIZE  = REPORT_BYTES * MAX_PACKETS;
  localparam int unsigned REPORT_LIMIT = 10;

  // predicted reassembly state
  logic [POS_W-1:0]   rpt_pos;
  logic [FIELD_W-1:0] hdr_total;
  logic [FIELD_W-1:0] hdr_packet;
  logic [FIELD_W-1:0] hdr_rest;
  logic [FIELD_W-1:0] packet_due;
  logic               packet_taken;

  result_t awaited_writes[$];

  // advance the reassembly by one byte and return the write it causes
  function automatic result_t reassemble_byte(input logic [7:0] b, input logic eor);
    result_t     r;
    logic        last_pkt;
    logic [31:0] offset;
    logic [31:0] limit;
    logic [31:0] addr;
    r = '0;
    last_pkt = 1'b0;
    case (rpt_pos)
      POS_TOTAL_LO: hdr_total = {8'h00, b};
      POS_TOTAL_HI: hdr_total[15:8] = b;
      POS_PKT_LO:   hdr_packet = {8'h00, b};
      POS_PKT_HI:   hdr_packet[15:8] = b;
      POS_REST_LO:  hdr_rest = {8'h00, b};
      POS_REST_HI: begin
        hdr_rest[15:8] = b;
        packet_taken = (hdr_packet == packet_due);
      end
      default: begin
        if (packet_taken) begin
          offset = 32'(rpt_pos) - HEADER_BYTES;
          limit = PAYLOAD_SIZE;
          last_pkt = (hdr_total != '0) && (hdr_packet == hdr_total - 16'd1);
          // the final packet carries only its rest, never more than a payload
          if (last_pkt && 32'(hdr_rest) < limit) begin
            limit = 32'(hdr_rest);
          end
          if (offset < limit) begin
            addr = 32'(hdr_packet) * PAYLOAD_SIZE + offset;
            if (addr < BUFFER_SIZE) begin
              r.write_enable = 1'b1;
              r.write_address = addr[ADDR_W-1:0];
              r.write_data = b;
            end
          end
        end
      end
    endcase

    // end of report: judge the packet, restart the byte position
    if (eor) begin
      if (rpt_pos >= POS_REST_HI) begin
        last_pkt = (hdr_total != '0) && (hdr_packet == hdr_total - 16'd1);
        if (packet_taken && last_pkt) begin
          r.message_done = 1'b1;
          packet_due = '0;
        end else if (packet_taken) begin
          packet_due = packet_due + 16'd1;
        end else begin
          r.sequence_error = 1'b1;
          packet_due = '0;
        end
      end
      rpt_pos = '0;
      packet_taken = 1'b0;
    end else if (rpt_pos != POS_MAX) begin
      rpt_pos = rpt_pos + 1'b1;
    end
    return r;
  endfunction

  // predict on every accepted request, compare on every accepted result
  always @(posedge clk) begin
    result_t seen;
    result_t due;
    if (rst) begin
      rpt_pos = '0;
      hdr_total = '0;
      hdr_packet = '0;
      hdr_rest = '0;
      packet_due = '0;
      packet_taken = 1'b0;
      awaited_writes.delete();
    end else begin
      if (in_stream.valid && in_stream.ready) begin
        awaited_writes.push_back(reassemble_byte(in_stream.data_byte,
                                                 in_stream.end_of_report));
      end
      if (out_stream.valid && out_stream.ready) begin
        seen.write_enable = out_stream.write_enable;
        seen.write_address = out_stream.write_address;
        seen.write_data = out_stream.write_data;
        seen.message_done = out_stream.message_done;
        seen.sequence_error = out_stream.sequence_error;
        if (awaited_writes.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: result with nothing awaited: we=%0b addr=%h data=%h done=%0b err=%0b",
                     $realtime, seen.write_enable, seen.write_address, seen.write_data,
                     seen.message_done, seen.sequence_error);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          due = awaited_writes.pop_front();
          if (seen.write_enable !== due.write_enable
              || seen.write_address !== due.write_address
              || seen.write_data !== due.write_data
              || seen.message_done !== due.message_done
              || seen.sequence_error !== due.sequence_error) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: expected we=%0b addr=%h data=%h done=%0b err=%0b",
                       $realtime, due.write_enable, due.write_address, due.write_data,
                       due.message_done, due.sequence_error);
              $display("%0t:   actual we=%0b addr=%h data=%h done=%0b err=%0b",
                       $realtime, seen.write_enable, seen.write_address, seen.write_data,
                       seen.message_done, seen.sequence_error);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    writes_outstanding <= awaited_writes.size();
  end

endmodule

FILE: verif/sequenced_report_reassembler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequenced_report_reassembler_test
// Feeds the reassembler with numbered reports: a short directed opening,
// then random messages made mostly of in-order packets with some stubs and
// out-of-order packets, then a message that walks up to the buffer end and
// closes with an over-long final packet. Both sides stall at random; a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sequenced_report_reassembler_test;
  import srr_pkg::*;

  localparam int REPORT_BYTES = 1024;
  localparam int MAX_PACKETS  = 34;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_PAYLOAD = 1024;
  localparam int PHASE_BYTES  = 80;
  localparam int BOUNDARY_PKT = MAX_PACKETS;
  localparam logic [15:0] LAST_TOTAL = 16'(MAX_PACKETS + 1);

  logic        clk;
  logic        rst;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 9;
  int          recv_idle_pct = 76;
  int unsigned bytes_sent = 0;
  logic [15:0] pkt_due;
  logic [15:0] msg_total;
  int unsigned mismatch_count;
  int unsigned writes_outstanding;

  srr_in_if  in_if();
  srr_out_if out_if();

  sequenced_report_reassembler #(
    .REPORT_BYTES (REPORT_BYTES),
    .MAX_PACKETS  (MAX_PACKETS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  sequenced_report_reassembler_checker #(
    .REPORT_BYTES (REPORT_BYTES),
    .MAX_PACKETS  (MAX_PACKETS)
  ) write_check (
    .clk                (clk),
    .rst                (rst),
    .in_stream          (in_if),
    .out_stream         (out_if),
    .mismatch_count     (mismatch_count),
    .writes_outstanding (writes_outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one byte request, with random gaps before it
  task automatic put_byte(input logic [7:0] b, input logic eor);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_report <= eor;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  // report that ends inside its header
  task automatic send_stub(input int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom), i == n - 1);
  endtask

  // full header plus payload; tracks the packet number the block expects next
  task automatic send_report(input logic [15:0] total, input logic [15:0] pkt,
                             input logic [15:0] rest, input int payload_len);
    logic [7:0] hdr [HEADER_BYTES];
    logic       last_pkt;
    hdr = '{total[7:0], total[15:8], pkt[7:0], pkt[15:8], rest[7:0], rest[15:8]};
    for (int i = 0; i < HEADER_BYTES; i++) begin
      put_byte(hdr[i], payload_len == 0 && i == HEADER_BYTES - 1);
    end
    for (int i = 0; i < payload_len; i++) put_byte(8'($urandom), i == payload_len - 1);
    last_pkt = (total != 16'd0) && (pkt == total - 16'd1);
    if (pkt != pkt_due || last_pkt) begin
      pkt_due = 16'd0;
    end else begin
      pkt_due = pkt_due + 16'd1;
    end
  endtask

  // mostly in-order messages, some stubs and out-of-order packets
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int          pick;
    logic [15:0] rest;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_stub($urandom_range(5, 1));
      end else if (pick < 16) begin
        send_report(16'($urandom), pkt_due + 16'($urandom_range(65535, 1)),
                    16'($urandom), $urandom_range(12, 0));
      end else begin
        // a new message starts whenever packet 0 is due
        if (pkt_due == 16'd0) begin
          case ($urandom_range(19))
            0:       msg_total = 16'd0;
            1:       msg_total = 16'($urandom);
            default: msg_total = 16'($urandom_range(5, 1));
          endcase
        end
        rest = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(14));
        send_report(msg_total, pkt_due, rest, $urandom_range(14, 0));
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst <= 1'b1;
    in_if.valid <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.end_of_report <= 1'b0;
    pkt_due = 16'd0;
    msg_total = 16'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // stub, final packet ending on the last header byte, short rest, bad number
    send_stub(2);
    send_report(16'd1, 16'd0, 16'd0, 0);
    send_report(16'd1, 16'd0, 16'd2, 4);
    send_report(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);

    random_traffic(PHASE_BYTES);
    send_idle_pct = 76;
    recv_idle_pct = 9;
    random_traffic(PHASE_BYTES);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(PHASE_BYTES);

    // drop back to packet 0, then walk header-only packets (the last with a short payload) up to the buffer end
    send_report(16'd1, pkt_due + 16'd1, 16'd0, 0);
    for (int p = 0; p < BOUNDARY_PKT; p++) begin
      send_report(LAST_TOTAL, 16'(p), 16'($urandom), (p == BOUNDARY_PKT - 1) ? 8 : 0);
    end
    // over-long final packet with an oversized rest, running past the buffer end
    send_report(LAST_TOTAL, 16'(BOUNDARY_PKT), 16'hFFFF, LONG_PAYLOAD);
    // a new message starts from packet 0 again
    send_report(16'd1, 16'd0, 16'd3, 5);

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (writes_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/srr_pkg.sv
src/srr_if.sv
src/srr_in_stage.sv
src/srr_track.sv
src/srr_out_stage.sv
src/sequenced_report_reassembler.sv
verif/sequenced_report_reassembler_checker.sv
verif/sequenced_report_reassembler_test.sv
